>>> src/spvg_pkg.sv
// ----------------------------------------------------------------------------
// Sphere patch vertex generator package
// Shared constants, CORDIC arctangent table, register indexes and word types.
// ----------------------------------------------------------------------------
package spvg_pkg;

    localparam int CORDIC_STAGES  = 16;
    localparam int MAX_RESOLUTION = 256;
    localparam int MAX_SEGMENTS   = 4096;

    // Fractional divider: floor(2^FRAC_BITS * n / d) with n <= d
    localparam int FRAC_BITS = 32;
    localparam int DIV_W     = 26;
    localparam int DIV_LAT   = FRAC_BITS + 1;

    // CORDIC datapath and trig result widths (Q30)
    localparam int CW       = 34;
    localparam int TRIG_W   = 32;
    localparam int CORD_LAT = CORDIC_STAGES + 2;

    localparam logic [30:0]          HALF_PI_Q30 = 31'd1686629713;
    localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30     = 34'sd1073741824;

    localparam logic signed [CW-1:0] ATAN_TAB [30] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
        34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128,
        34'sd64,        34'sd32,        34'sd16,        34'sd8,
        34'sd4,         34'sd2
    };

    typedef enum logic [2:0] {
        REG_LNG_DIVISIONS  = 3'd0,
        REG_LAT_DIVISIONS  = 3'd1,
        REG_LAT_BAND       = 3'd2,
        REG_RESOLUTION     = 3'd3,
        REG_BASE_SEGMENTS  = 3'd4,
        REG_REDUCE_MODE    = 3'd5,
        REG_OUTSIDE_FACING = 3'd6,
        REG_SHIFT_ORIGIN   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [8:0]  strip_index;
        logic [12:0] segment_index;
    } point_t;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic [18:0]        micro_u;
        logic [18:0]        micro_v;
        logic               point_invalid;
    } vertex_t;

    // Sideband carried alongside the divider pipeline
    typedef struct packed {
        logic bad;
        logic nzero;
    } div_side_t;

    // Sideband carried alongside the CORDIC pipeline
    typedef struct packed {
        logic        bad;
        logic        nzero;
        logic [16:0] tu;
        logic [16:0] tv;
    } trig_side_t;

endpackage

>>> src/sphere_patch_vertex_generator_top.sv
// ----------------------------------------------------------------------------
// Sphere patch vertex generator, top level
// Throughput: one point word per cycle unless the vertex side stalls;
//   the fractional dividers (33 stages) and CORDIC units (18 stages)
//   are fully pipelined.
// Stall on the vertex side freezes the whole pipeline while a result is held.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module sphere_patch_vertex_generator_top (
    input  logic               clk,
    input  logic               rst_n,
    // point channel
    input  logic               point_valid,
    output logic               point_stall,
    input  spvg_pkg::point_t   point,
    // vertex channel
    output logic               vertex_valid,
    input  logic               vertex_stall,
    output spvg_pkg::vertex_t  vertex,
    // configuration
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [13:0]        cfg_data
);
    import spvg_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [12:0]        lng_div_reg;
    logic [10:0]        lat_div_reg;
    logic [9:0]         lat_band_reg;
    logic [8:0]         res_reg;
    logic signed [13:0] base_seg_reg;
    logic               reduce_reg;
    logic               outside_reg;
    logic               shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lng_div_reg  <= 13'd1;
            lat_div_reg  <= 11'd1;
            lat_band_reg <= '0;
            res_reg      <= 9'd1;
            base_seg_reg <= -14'sd1;
            reduce_reg   <= 1'b0;
            outside_reg  <= 1'b1;
            shift_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LNG_DIVISIONS:  lng_div_reg  <= cfg_data[12:0];
                REG_LAT_DIVISIONS:  lat_div_reg  <= cfg_data[10:0];
                REG_LAT_BAND:       lat_band_reg <= cfg_data[9:0];
                REG_RESOLUTION:     res_reg      <= cfg_data[8:0];
                REG_BASE_SEGMENTS:  base_seg_reg <= $signed(cfg_data);
                REG_REDUCE_MODE:    reduce_reg   <= cfg_data[0];
                REG_OUTSIDE_FACING: outside_reg  <= cfg_data[0];
                REG_SHIFT_ORIGIN:   shift_reg    <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Global advance: the pipeline moves unless the held vertex is stalled
    // ------------------------------------------------------------------
    logic adv;
    logic out_valid_reg;

    assign adv         = !out_valid_reg || !vertex_stall;
    assign point_stall = !adv;

    // ------------------------------------------------------------------
    // Stage F1: segment count, latitude numerators and denominator
    // ------------------------------------------------------------------
    logic        f1_valid_reg;
    logic [8:0]  f1_i_reg;
    logic [12:0] f1_j_reg;
    logic [19:0] f1_seg_reg;
    logic [19:0] f1_lat_num_reg;
    logic [19:0] f1_lat0_num_reg;
    logic [21:0] f1_lat_den_reg;
    logic        f1_cfg_bad_reg;

    logic [10:0] lat_gap;
    logic        use_auto;
    logic [19:0] seg_next;
    logic [19:0] lat0_num_next;
    logic [19:0] lat_num_next;
    logic [21:0] lat_den_next;
    logic        cfg_bad_next;

    always_comb
    begin
        lat_gap       = lat_div_reg - {1'b0, lat_band_reg};
        use_auto      = base_seg_reg[13] || ({1'b0, lat_band_reg} + 11'd1 == lat_div_reg);
        seg_next      = use_auto ? 20'(lat_gap * res_reg) : {7'd0, base_seg_reg[12:0]};
        lat0_num_next = 20'(lat_band_reg * res_reg);
        lat_num_next  = lat0_num_next + {11'd0, point.strip_index};
        lat_den_next  = {20'(lat_div_reg * res_reg), 2'b00};
        cfg_bad_next  = (lng_div_reg == '0) || (lat_div_reg == '0) || (res_reg == '0)
                        || ({23'd0, res_reg} > 32'(MAX_RESOLUTION))
                        || ({1'b0, lat_band_reg} >= lat_div_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_i_reg        <= point.strip_index;
            f1_j_reg        <= point.segment_index;
            f1_seg_reg      <= seg_next;
            f1_lat_num_reg  <= lat_num_next;
            f1_lat0_num_reg <= lat0_num_next;
            f1_lat_den_reg  <= lat_den_next;
            f1_cfg_bad_reg  <= cfg_bad_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage F2: strip segment count, range checks, longitude denominator
    // ------------------------------------------------------------------
    logic        f2_valid_reg;
    logic        f2_bad_reg;
    logic        f2_nzero_reg;
    logic [19:0] f2_lat_num_reg;
    logic [19:0] f2_lat0_num_reg;
    logic [21:0] f2_lat_den_reg;
    logic [25:0] f2_lng_den_reg;
    logic [12:0] f2_j_reg;
    logic [12:0] f2_nseg_reg;
    logic [8:0]  f2_tv_num_reg;

    logic signed [20:0] nseg_next;
    logic               bad_next;

    always_comb
    begin
        if (reduce_reg)
        begin
            nseg_next = $signed({1'b0, f1_seg_reg}) - $signed({12'd0, f1_i_reg});
        end
        else
        begin
            nseg_next = $signed({1'b0, f1_seg_reg});
        end
        bad_next = f1_cfg_bad_reg || ({12'd0, f1_seg_reg} > 32'(MAX_SEGMENTS))
                   || (f1_i_reg > res_reg) || nseg_next[20]
                   || ($signed({8'd0, f1_j_reg}) > nseg_next);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f2_bad_reg      <= bad_next;
            f2_nzero_reg    <= (nseg_next == '0);
            f2_lat_num_reg  <= f1_lat_num_reg;
            f2_lat0_num_reg <= f1_lat0_num_reg;
            f2_lat_den_reg  <= f1_lat_den_reg;
            f2_lng_den_reg  <= 26'(nseg_next[12:0] * lng_div_reg);
            f2_j_reg        <= f1_j_reg;
            f2_nseg_reg     <= nseg_next[12:0];
            f2_tv_num_reg   <= res_reg - f1_i_reg;
        end
    end

    // ------------------------------------------------------------------
    // Fractional dividers: latitude, patch corner latitude, longitude,
    // and the two texture ratios
    // ------------------------------------------------------------------
    logic [FRAC_BITS:0] q_lat;
    logic [FRAC_BITS:0] q_lat0;
    logic [FRAC_BITS:0] q_lng;
    logic [FRAC_BITS:0] q_tu;
    logic [FRAC_BITS:0] q_tv;

    spvg_div u_div_lat (
        .clk (clk),
        .en  (adv),
        .num (DIV_W'(f2_lat_num_reg)),
        .den (DIV_W'(f2_lat_den_reg)),
        .quo (q_lat)
    );

    spvg_div u_div_lat0 (
        .clk (clk),
        .en  (adv),
        .num (DIV_W'(f2_lat0_num_reg)),
        .den (DIV_W'(f2_lat_den_reg)),
        .quo (q_lat0)
    );

    spvg_div u_div_lng (
        .clk (clk),
        .en  (adv),
        .num (DIV_W'(f2_j_reg)),
        .den (f2_lng_den_reg),
        .quo (q_lng)
    );

    spvg_div u_div_tu (
        .clk (clk),
        .en  (adv),
        .num (DIV_W'(f2_j_reg)),
        .den (DIV_W'(f2_nseg_reg)),
        .quo (q_tu)
    );

    spvg_div u_div_tv (
        .clk (clk),
        .en  (adv),
        .num (DIV_W'(f2_tv_num_reg)),
        .den (DIV_W'(res_reg)),
        .quo (q_tv)
    );

    // hold the check results alongside the dividers
    logic      va_reg [DIV_LAT];
    div_side_t sa_reg [DIV_LAT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_reg[0] <= '{bad: f2_bad_reg, nzero: f2_nzero_reg};
            for (int k = 1; k < DIV_LAT; k++)
            begin
                sa_reg[k] <= sa_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Texture rounding and CORDIC angle selection
    // ------------------------------------------------------------------
    div_side_t  sa_out;
    logic [17:0] tu_sum;
    logic [17:0] tv_sum;
    trig_side_t sb_next;
    logic [31:0] lng_turn;

    always_comb
    begin
        sa_out = sa_reg[DIV_LAT-1];
        // round half up: (floor(2^17 n / d) + 1) / 2
        tu_sum = q_tu[FRAC_BITS:FRAC_BITS-17] + 18'd1;
        tv_sum = q_tv[FRAC_BITS:FRAC_BITS-17] + 18'd1;
        sb_next.bad   = sa_out.bad;
        sb_next.nzero = sa_out.nzero;
        sb_next.tu    = tu_sum[17:1];
        sb_next.tv    = tv_sum[17:1];
        // zero segments: longitude stays at zero; a full turn wraps to zero
        lng_turn = sa_out.nzero ? 32'd0 : q_lng[31:0];
    end

    logic signed [TRIG_W-1:0] clat;
    logic signed [TRIG_W-1:0] slat;
    logic signed [TRIG_W-1:0] clat0;
    logic signed [TRIG_W-1:0] slat0;
    logic signed [TRIG_W-1:0] clng;
    logic signed [TRIG_W-1:0] slng;

    spvg_cordic u_cordic_lat (
        .clk     (clk),
        .en      (adv),
        .turn    (q_lat[31:0]),
        .cos_q30 (clat),
        .sin_q30 (slat)
    );

    spvg_cordic u_cordic_lat0 (
        .clk     (clk),
        .en      (adv),
        .turn    (q_lat0[31:0]),
        .cos_q30 (clat0),
        .sin_q30 (slat0)
    );

    spvg_cordic u_cordic_lng (
        .clk     (clk),
        .en      (adv),
        .turn    (lng_turn),
        .cos_q30 (clng),
        .sin_q30 (slng)
    );

    // hold flags and texture values alongside the CORDIC units
    logic       vb_reg [CORD_LAT];
    trig_side_t sb_reg [CORD_LAT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb_reg[0] <= sb_next;
            for (int k = 1; k < CORD_LAT; k++)
            begin
                sb_reg[k] <= sb_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage B1: products and Q30 to Q14 rounding of the plain terms
    // ------------------------------------------------------------------
    logic               b1_valid_reg;
    trig_side_t         b1_side_reg;
    logic signed [63:0] b1_px_reg;
    logic signed [63:0] b1_pz_reg;
    logic signed [16:0] b1_ny_reg;
    logic signed [16:0] b1_cx0_reg;
    logic signed [16:0] b1_sy0_reg;

    logic signed [TRIG_W:0] slat_rnd;
    logic signed [TRIG_W:0] clat0_rnd;
    logic signed [TRIG_W:0] slat0_rnd;

    always_comb
    begin
        slat_rnd  = ((TRIG_W+1)'(slat)  + (TRIG_W+1)'(32768)) >>> 16;
        clat0_rnd = ((TRIG_W+1)'(clat0) + (TRIG_W+1)'(32768)) >>> 16;
        slat0_rnd = ((TRIG_W+1)'(slat0) + (TRIG_W+1)'(32768)) >>> 16;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_side_reg <= sb_reg[CORD_LAT-1];
            b1_px_reg   <= 64'(clat) * 64'(clng);
            b1_pz_reg   <= 64'(clat) * 64'(slng);
            b1_ny_reg   <= slat_rnd[16:0];
            b1_cx0_reg  <= clat0_rnd[16:0];
            b1_sy0_reg  <= slat0_rnd[16:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage B2: round products, shift origin, facing, output word
    // ------------------------------------------------------------------
    logic signed [63:0] px_rnd;
    logic signed [63:0] pz_rnd;
    logic signed [15:0] nx16;
    logic signed [15:0] ny16;
    logic signed [15:0] nz16;
    logic signed [16:0] px17;
    logic signed [16:0] py17;
    vertex_t            vertex_next;
    vertex_t            vertex_reg;

    always_comb
    begin
        px_rnd = b1_px_reg + (64'sd1 <<< 45);
        pz_rnd = b1_pz_reg + (64'sd1 <<< 45);
        nx16   = px_rnd[61:46];
        nz16   = pz_rnd[61:46];
        ny16   = b1_ny_reg[15:0];
        px17   = 17'(nx16);
        py17   = b1_ny_reg;
        if (shift_reg)
        begin
            px17 = px17 - b1_cx0_reg;
            py17 = py17 - b1_sy0_reg;
        end

        vertex_next = '0;
        if (b1_side_reg.bad)
        begin
            vertex_next.point_invalid = 1'b1;
        end
        else
        begin
            vertex_next.pos_x  = px17[15:0];
            vertex_next.pos_y  = py17[15:0];
            vertex_next.pos_z  = nz16;
            vertex_next.norm_x = outside_reg ? nx16 : -nx16;
            vertex_next.norm_y = outside_reg ? ny16 : -ny16;
            vertex_next.norm_z = outside_reg ? nz16 : -nz16;
            vertex_next.tex_v   = b1_side_reg.tv;
            vertex_next.micro_v = {b1_side_reg.tv, 2'b00};
            if (b1_side_reg.nzero)
            begin
                vertex_next.tex_u   = 17'd32768;
                vertex_next.micro_u = 19'd32768;
            end
            else
            begin
                vertex_next.tex_u   = b1_side_reg.tu;
                vertex_next.micro_u = {b1_side_reg.tu, 2'b00};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vertex_reg <= vertex_next;
        end
    end

    // ------------------------------------------------------------------
    // Valid bits: advance with the data, clear on reset
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++)
            begin
                va_reg[k] <= 1'b0;
            end
            for (int k = 0; k < CORD_LAT; k++)
            begin
                vb_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            f1_valid_reg <= point_valid;
            f2_valid_reg <= f1_valid_reg;
            va_reg[0]    <= f2_valid_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                va_reg[k] <= va_reg[k-1];
            end
            vb_reg[0] <= va_reg[DIV_LAT-1];
            for (int k = 1; k < CORD_LAT; k++)
            begin
                vb_reg[k] <= vb_reg[k-1];
            end
            b1_valid_reg  <= vb_reg[CORD_LAT-1];
            out_valid_reg <= b1_valid_reg;
        end
    end

    assign vertex_valid = out_valid_reg;
    assign vertex       = vertex_reg;

endmodule

>>> src/spvg_div.sv
// ----------------------------------------------------------------------------
// Pipelined fractional divider
// Restoring division, one quotient bit per stage: quo = floor(2^32 * num / den).
// ----------------------------------------------------------------------------
module spvg_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [spvg_pkg::DIV_W-1:0]    num,
    input  logic [spvg_pkg::DIV_W-1:0]    den,
    output logic [spvg_pkg::FRAC_BITS:0]  quo
);
    import spvg_pkg::*;

    logic [DIV_W-1:0]     rem_reg  [DIV_LAT];
    logic [DIV_W-1:0]     den_reg  [DIV_LAT];
    logic [FRAC_BITS:0]   quo_reg  [DIV_LAT];
    logic [DIV_W-1:0]     rem_next [DIV_LAT];
    logic [FRAC_BITS:0]   quo_next [DIV_LAT];

    always_comb
    begin
        logic [DIV_W:0] shifted;
        shifted = '0;
        // integer bit: num equals den at most
        if (num >= den)
        begin
            rem_next[0] = num - den;
            quo_next[0] = {{FRAC_BITS{1'b0}}, 1'b1};
        end
        else
        begin
            rem_next[0] = num;
            quo_next[0] = '0;
        end
        for (int k = 1; k < DIV_LAT; k++)
        begin
            shifted = {rem_reg[k-1], 1'b0};
            if (shifted >= {1'b0, den_reg[k-1]})
            begin
                rem_next[k] = DIV_W'(shifted - {1'b0, den_reg[k-1]});
                quo_next[k] = {quo_reg[k-1][FRAC_BITS-1:0], 1'b1};
            end
            else
            begin
                rem_next[k] = shifted[DIV_W-1:0];
                quo_next[k] = {quo_reg[k-1][FRAC_BITS-1:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= den;
            for (int k = 0; k < DIV_LAT; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
            end
            for (int k = 1; k < DIV_LAT; k++)
            begin
                den_reg[k] <= den_reg[k-1];
            end
        end
    end

    assign quo = quo_reg[DIV_LAT-1];

endmodule

>>> src/spvg_cordic.sv
// ----------------------------------------------------------------------------
// Pipelined CORDIC sine and cosine
// Turn angle to Q30 radians, one rotation per stage, clamp and quadrant fold.
// ----------------------------------------------------------------------------
module spvg_cordic (
    input  logic                              clk,
    input  logic                              en,
    input  logic [31:0]                       turn,
    output logic signed [spvg_pkg::TRIG_W-1:0] cos_q30,
    output logic signed [spvg_pkg::TRIG_W-1:0] sin_q30
);
    import spvg_pkg::*;

    logic signed [CW-1:0]    x_reg [CORDIC_STAGES+1];
    logic signed [CW-1:0]    y_reg [CORDIC_STAGES+1];
    logic signed [CW-1:0]    z_reg [CORDIC_STAGES+1];
    logic [1:0]              quad_reg [CORDIC_STAGES+1];
    logic signed [CW-1:0]    x_next [CORDIC_STAGES+1];
    logic signed [CW-1:0]    y_next [CORDIC_STAGES+1];
    logic signed [CW-1:0]    z_next [CORDIC_STAGES+1];
    logic [60:0]             angle_prod;
    logic signed [CW-1:0]    xc;
    logic signed [CW-1:0]    yc;
    logic signed [CW-1:0]    cos_next;
    logic signed [CW-1:0]    sin_next;
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;

    assign angle_prod = turn[29:0] * HALF_PI_Q30;

    always_comb
    begin
        x_next[0] = GAIN_Q30;
        y_next[0] = '0;
        z_next[0] = $signed({3'b000, angle_prod[60:30]});
        for (int k = 0; k < CORDIC_STAGES; k++)
        begin
            if (!z_reg[k][CW-1])
            begin
                x_next[k+1] = x_reg[k] - (y_reg[k] >>> k);
                y_next[k+1] = y_reg[k] + (x_reg[k] >>> k);
                z_next[k+1] = z_reg[k] - ATAN_TAB[k];
            end
            else
            begin
                x_next[k+1] = x_reg[k] + (y_reg[k] >>> k);
                y_next[k+1] = y_reg[k] - (x_reg[k] >>> k);
                z_next[k+1] = z_reg[k] + ATAN_TAB[k];
            end
        end
    end

    // clamp to the unit range, then fold by quadrant
    always_comb
    begin
        xc = x_reg[CORDIC_STAGES];
        yc = y_reg[CORDIC_STAGES];
        if (xc > ONE_Q30)
        begin
            xc = ONE_Q30;
        end
        else if (xc < -ONE_Q30)
        begin
            xc = -ONE_Q30;
        end
        if (yc > ONE_Q30)
        begin
            yc = ONE_Q30;
        end
        else if (yc < -ONE_Q30)
        begin
            yc = -ONE_Q30;
        end
        case (quad_reg[CORDIC_STAGES])
            2'd0:
            begin
                cos_next = xc;
                sin_next = yc;
            end
            2'd1:
            begin
                cos_next = -yc;
                sin_next = xc;
            end
            2'd2:
            begin
                cos_next = -xc;
                sin_next = -yc;
            end
            default:
            begin
                cos_next = yc;
                sin_next = -xc;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quad_reg[0] <= turn[31:30];
            for (int k = 0; k <= CORDIC_STAGES; k++)
            begin
                x_reg[k] <= x_next[k];
                y_reg[k] <= y_next[k];
                z_reg[k] <= z_next[k];
            end
            for (int k = 1; k <= CORDIC_STAGES; k++)
            begin
                quad_reg[k] <= quad_reg[k-1];
            end
            cos_reg <= cos_next[TRIG_W-1:0];
            sin_reg <= sin_next[TRIG_W-1:0];
        end
    end

    assign cos_q30 = cos_reg;
    assign sin_q30 = sin_reg;

endmodule

>>> bench/sphere_patch_vertex_generator_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sphere patch vertex generator testbench
// Drives grid points under several register settings, predicts every vertex
// word with a bit-true CORDIC model and compares field by field.
// ----------------------------------------------------------------------------
module sphere_patch_vertex_generator_top_test;
    import spvg_pkg::*;

    localparam int PIPE_DEPTH = 55;

    logic       clk;
    logic       rst_n;
    logic       point_valid;
    logic       point_stall;
    point_t     point;
    logic       vertex_valid;
    logic       vertex_stall;
    vertex_t    vertex;
    logic       cfg_write;
    logic [2:0] cfg_index;
    logic [13:0] cfg_data;

    sphere_patch_vertex_generator_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point        (point),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .vertex       (vertex),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Shadow copy of the register file
    logic [12:0]        sh_lng_div;
    logic [10:0]        sh_lat_div;
    logic [9:0]         sh_lat_band;
    logic [8:0]         sh_res;
    logic signed [13:0] sh_base_seg;
    logic               sh_reduce;
    logic               sh_outside;
    logic               sh_shift;

    vertex_t expected_vertices[$];
    int      error_count;
    int      send_idle_pct;
    int      recv_idle_pct;
    logic    hold_off;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #80ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint floor_shift(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint clamp_q30(longint v);
        if (v > 64'sd1073741824)
            return 64'sd1073741824;
        if (v < -64'sd1073741824)
            return -64'sd1073741824;
        return v;
    endfunction

    // cos and sin in Q30 of an angle given as a fraction of a full turn
    task automatic turn_cos_sin(input logic [31:0] turn, output longint c, output longint s);
        longint x;
        longint y;
        longint z;
        longint nx;
        logic [63:0] prod;
        prod = {34'd0, turn[29:0]} * 64'd1686629713;
        z = longint'(prod >> 30);
        x = 652032874;
        y = 0;
        for (int k = 0; k < CORDIC_STAGES && k < 30; k++)
        begin
            if (z >= 0)
            begin
                nx = x - floor_shift(y, k);
                y  = y + floor_shift(x, k);
                z  = z - longint'(ATAN_TAB[k]);
            end
            else
            begin
                nx = x + floor_shift(y, k);
                y  = y - floor_shift(x, k);
                z  = z + longint'(ATAN_TAB[k]);
            end
            x = nx;
        end
        x = clamp_q30(x);
        y = clamp_q30(y);
        case (turn[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    function automatic longint q30_round(longint v);
        return (v + (64'sd1 <<< 15)) >>> 16;
    endfunction

    function automatic longint q60_round(longint v);
        return (v + (64'sd1 <<< 45)) >>> 46;
    endfunction

    // Compute the vertex word expected for one grid point
    task automatic predict_vertex(input point_t p, output vertex_t v);
        longint i;
        longint j;
        longint res;
        longint seg;
        longint nseg;
        logic   bad;
        logic [127:0] num;
        logic [127:0] den;
        logic [31:0] lat_t;
        logic [31:0] lat0_t;
        logic [31:0] lng_t;
        longint clat, slat, clng, slng, clat0, slat0;
        longint px, py, pz, nx, ny, nz;
        longint tu, tv, mu;
        i = p.strip_index;
        j = p.segment_index;
        res = sh_res;
        seg = 0;
        nseg = 0;
        bad = 1'b0;
        v = '0;
        if (sh_lng_div == 0 || sh_lat_div == 0 || res == 0 || res > MAX_RESOLUTION
            || sh_lat_band >= sh_lat_div)
            bad = 1'b1;
        else
        begin
            if (sh_base_seg < 0 || sh_lat_band == sh_lat_div - 1)
                seg = longint'(sh_lat_div - sh_lat_band) * res;
            else
                seg = sh_base_seg;
            nseg = sh_reduce ? seg - i : seg;
            if (seg > MAX_SEGMENTS || i > res || nseg < 0 || j > nseg)
                bad = 1'b1;
        end
        if (bad)
        begin
            v.point_invalid = 1'b1;
            return;
        end
        den = 128'(4 * sh_lat_div * res);
        num = 128'(sh_lat_band * res + i) << 32;
        lat_t = 32'(num / den);
        num = 128'(sh_lat_band * res) << 32;
        lat0_t = 32'(num / den);
        lng_t = '0;
        if (nseg != 0)
            lng_t = 32'((128'(j) << 32) / 128'(nseg * sh_lng_div));
        turn_cos_sin(lat_t, clat, slat);
        turn_cos_sin(lng_t, clng, slng);
        turn_cos_sin(lat0_t, clat0, slat0);
        nx = q60_round(clat * clng);
        ny = q30_round(slat);
        nz = q60_round(clat * slng);
        px = nx;
        py = ny;
        pz = nz;
        if (sh_shift)
        begin
            px -= q30_round(clat0);
            py -= q30_round(slat0);
        end
        if (!sh_outside)
        begin
            nx = -nx;
            ny = -ny;
            nz = -nz;
        end
        if (nseg != 0)
        begin
            tu = (j * 131072 + nseg) / (2 * nseg);
            mu = tu * 4;
        end
        else
        begin
            tu = 32768;
            mu = 32768;
        end
        tv = ((res - i) * 131072 + res) / (2 * res);
        v.pos_x   = 16'(px);
        v.pos_y   = 16'(py);
        v.pos_z   = 16'(pz);
        v.norm_x  = 16'(nx);
        v.norm_y  = 16'(ny);
        v.norm_z  = 16'(nz);
        v.tex_u   = 17'(tu);
        v.tex_v   = 17'(tv);
        v.micro_u = 19'(mu);
        v.micro_v = 19'(tv * 4);
        v.point_invalid = 1'b0;
    endtask

    // Check every accepted vertex word against the oldest expectation
    always @(posedge clk)
    begin
        vertex_t exp_v;
        if (rst_n && vertex_valid && !vertex_stall)
        begin
            if (expected_vertices.size() == 0)
            begin
                $error("vertex word with nothing expected");
                error_count++;
            end
            else
            begin
                exp_v = expected_vertices.pop_front();
                if (vertex.pos_x !== exp_v.pos_x)
                    begin $error("pos_x exp %0d got %0d", exp_v.pos_x, vertex.pos_x); error_count++; end
                if (vertex.pos_y !== exp_v.pos_y)
                    begin $error("pos_y exp %0d got %0d", exp_v.pos_y, vertex.pos_y); error_count++; end
                if (vertex.pos_z !== exp_v.pos_z)
                    begin $error("pos_z exp %0d got %0d", exp_v.pos_z, vertex.pos_z); error_count++; end
                if (vertex.norm_x !== exp_v.norm_x)
                    begin $error("norm_x exp %0d got %0d", exp_v.norm_x, vertex.norm_x); error_count++; end
                if (vertex.norm_y !== exp_v.norm_y)
                    begin $error("norm_y exp %0d got %0d", exp_v.norm_y, vertex.norm_y); error_count++; end
                if (vertex.norm_z !== exp_v.norm_z)
                    begin $error("norm_z exp %0d got %0d", exp_v.norm_z, vertex.norm_z); error_count++; end
                if (vertex.tex_u !== exp_v.tex_u)
                    begin $error("tex_u exp %0d got %0d", exp_v.tex_u, vertex.tex_u); error_count++; end
                if (vertex.tex_v !== exp_v.tex_v)
                    begin $error("tex_v exp %0d got %0d", exp_v.tex_v, vertex.tex_v); error_count++; end
                if (vertex.micro_u !== exp_v.micro_u)
                    begin $error("micro_u exp %0d got %0d", exp_v.micro_u, vertex.micro_u); error_count++; end
                if (vertex.micro_v !== exp_v.micro_v)
                    begin $error("micro_v exp %0d got %0d", exp_v.micro_v, vertex.micro_v); error_count++; end
                if (vertex.point_invalid !== exp_v.point_invalid)
                    begin
                        $error("point_invalid exp %0b got %0b", exp_v.point_invalid,
                               vertex.point_invalid);
                        error_count++;
                    end
            end
        end
    end

    // Receiver: random stall, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_off)
            vertex_stall <= 1'b1;
        else
            vertex_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Write one register and mirror it in the shadow copy
    task automatic write_reg(input cfg_reg_t idx, input logic [13:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_LNG_DIVISIONS:  sh_lng_div  = data[12:0];
            REG_LAT_DIVISIONS:  sh_lat_div  = data[10:0];
            REG_LAT_BAND:       sh_lat_band = data[9:0];
            REG_RESOLUTION:     sh_res      = data[8:0];
            REG_BASE_SEGMENTS:  sh_base_seg = data;
            REG_REDUCE_MODE:    sh_reduce   = data[0];
            REG_OUTSIDE_FACING: sh_outside  = data[0];
            default:            sh_shift    = data[0];
        endcase
    endtask

    task automatic load_config(input int lng, input int lat, input int band, input int res,
                               input int bseg, input bit red, input bit outs, input bit shf);
        write_reg(REG_LNG_DIVISIONS, 14'(lng));
        write_reg(REG_LAT_DIVISIONS, 14'(lat));
        write_reg(REG_LAT_BAND, 14'(band));
        write_reg(REG_RESOLUTION, 14'(res));
        write_reg(REG_BASE_SEGMENTS, 14'(bseg));
        write_reg(REG_REDUCE_MODE, 14'(red));
        write_reg(REG_OUTSIDE_FACING, 14'(outs));
        write_reg(REG_SHIFT_ORIGIN, 14'(shf));
        cfg_write <= 1'b0;
    endtask

    // Offer one point word, hold it until accepted, then queue its prediction
    task automatic send_point(input point_t p);
        vertex_t v;
        while ($urandom_range(99) < send_idle_pct)
        begin
            point_valid <= 1'b0;
            @(posedge clk);
        end
        point_valid <= 1'b1;
        point       <= p;
        @(posedge clk);
        while (point_stall)
            @(posedge clk);
        predict_vertex(p, v);
        expected_vertices.push_back(v);
    endtask

    // Drain: drop valid, wait for every expected word, then let the pipe settle
    task automatic drain();
        point_valid <= 1'b0;
        while (expected_vertices.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
    endtask

    // Directed table: grid points under the reset registers, with expected words
    // that are obvious (invalid points are all-zero with the flag set)
    typedef struct {
        point_t  p;
        bit      typed;
        vertex_t v;
    } directed_row_t;

    directed_row_t directed_rows[$];

    task automatic add_row(input int s, input int g, input bit typed, input vertex_t v);
        directed_row_t r;
        r.p.strip_index   = 9'(s);
        r.p.segment_index = 13'(g);
        r.typed = typed;
        r.v = v;
        directed_rows.push_back(r);
    endtask

    // Random point: mostly inside the grid, sometimes beyond it or at full width
    function automatic point_t random_point();
        point_t p;
        int nseg_max;
        nseg_max = (sh_base_seg < 0) ? (sh_lat_div - sh_lat_band) * sh_res : sh_base_seg;
        if (nseg_max < 0)
            nseg_max = 0;
        if (nseg_max > 8191)
            nseg_max = 8191;
        if ($urandom_range(9) == 0)
        begin
            p.strip_index   = 9'($urandom);
            p.segment_index = 13'($urandom);
        end
        else
        begin
            p.strip_index   = 9'($urandom_range(sh_res > 511 ? 511 : sh_res));
            p.segment_index = 13'($urandom_range(nseg_max + 1));
        end
        return p;
    endfunction

    initial
    begin
        vertex_t zero_bad;
        int n_items;
        int phase;
        rst_n        = 1'b0;
        point_valid  = 1'b0;
        point        = '0;
        cfg_write    = 1'b0;
        cfg_index    = REG_LNG_DIVISIONS;
        cfg_data     = '0;
        hold_off     = 1'b0;
        error_count  = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        sh_lng_div = 13'd1;
        sh_lat_div = 11'd1;
        sh_lat_band = 10'd0;
        sh_res = 9'd1;
        sh_base_seg = -14'sd1;
        sh_reduce = 1'b0;
        sh_outside = 1'b1;
        sh_shift = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: one strip, automatic count of 1 segment
        zero_bad = '0;
        zero_bad.point_invalid = 1'b1;
        add_row(0, 0, 1'b0, zero_bad);
        add_row(0, 1, 1'b0, zero_bad);
        add_row(1, 0, 1'b0, zero_bad);
        // Pole of the first band: strip at the top, tex_v of zero
        add_row(1, 1, 1'b0, zero_bad);
        add_row(2, 0, 1'b1, zero_bad);
        add_row(0, 2, 1'b1, zero_bad);
        add_row(511, 8191, 1'b1, zero_bad);
        add_row(0, 8191, 1'b1, zero_bad);
        add_row(511, 0, 1'b1, zero_bad);
        foreach (directed_rows[k])
        begin
            send_point(directed_rows[k].p);
            if (directed_rows[k].typed)
                expected_vertices[expected_vertices.size() - 1] = directed_rows[k].v;
        end
        drain();

        // Directed extremes of the registers
        load_config(0, 1, 0, 1, -1, 0, 1, 0);
        send_point('0);
        drain();
        load_config(1, 1, 0, 257, -1, 0, 1, 0);
        send_point('0);
        drain();
        load_config(1, 4, 4, 1, -1, 0, 1, 0);
        send_point('0);
        drain();
        // Overflowing segment count, then the widest legal one
        load_config(4096, 1024, 0, 256, 4097, 0, 0, 1);
        send_point('0);
        drain();
        load_config(4096, 1024, 1019, 256, 4096, 0, 0, 1);
        send_point('{9'd0, 13'd4096});
        send_point('{9'd256, 13'd0});
        send_point('{9'd256, 13'd4097});
        send_point('{9'd257, 13'd0});
        drain();
        // Zero-segment strip under triangular reduction, base 3 and res 3
        load_config(3, 8, 2, 3, 3, 1, 0, 1);
        send_point('{9'd3, 13'd0});
        send_point('{9'd3, 13'd1});
        send_point('{9'd2, 13'd1});
        send_point('{9'd0, 13'd3});
        send_point('{9'd4, 13'd0});
        drain();
        // Negative base segments other than -1 behave as automatic
        load_config(8191, 2047, 1023, 511, 14'h2000, 1, 1, 0);
        send_point('{9'd0, 13'd0});
        drain();

        // Random part in three idling phases, a fresh setting per block
        n_items = 0;
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 74 : 0;
            recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 27 : 0;
            for (int blk = 0; blk < 6; blk++)
            begin
                int lat;
                int band;
                int res;
                lat  = $urandom_range(12, 1);
                band = ($urandom_range(7) == 0) ? lat : $urandom_range(lat - 1);
                res  = ($urandom_range(9) == 0) ? 256 : $urandom_range(8, 1);
                load_config(($urandom_range(3) == 0) ? $urandom_range(8191)
                                                    : $urandom_range(16, 1),
                            lat, band, res,
                            ($urandom_range(2) == 0) ? -1 : $urandom_range(40),
                            $urandom_range(1), $urandom_range(1), $urandom_range(1));
                if (phase == 2 && blk == 0)
                begin
                    // Long receiver hold-off while points keep coming
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (150) @(posedge clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                repeat (92)
                begin
                    send_point(random_point());
                    n_items++;
                end
                drain();
            end
        end

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
